// ----- hdl/minv_pkg.sv -----
// shared widths and the division pipeline beat type for the 3x3 inverse
// no dependencies; used by the division step and the top level
package minv_pkg;

    localparam int NUM_EL    = 9;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int COF_W     = PROD_W + 1;
    localparam int DET_W     = 97;
    localparam int MAG_W     = DET_W - 1;
    localparam int DIV_STEPS = DATA_W;
    localparam int FRONT_STG = 6;

    typedef struct packed {
        logic [NUM_EL-1:0][MAG_W-1:0]  rem;
        logic [NUM_EL-1:0][DATA_W-1:0] quo;
        logic [MAG_W-1:0]              dm;
        logic [NUM_EL-1:0]             big;
        logic [NUM_EL-1:0]             neg;
        logic                          sing;
    } div_t;

endpackage

// ----- hdl/minv_if.sv -----
// valid/ready channel interfaces for matrix in and inverse out
// depends on nothing
interface minv_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface minv_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic singular;
    logic overflowed;
    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, overflowed, input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, overflowed, output ready);
endinterface

// ----- hdl/minv_div_step.sv -----
// one restoring division step for all nine elements, registered
// depends on minv_pkg
module minv_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  minv_pkg::div_t d_in,
    output logic          vld_reg,
    output minv_pkg::div_t d_reg
);

    minv_pkg::div_t d_next;

    always_comb
    begin
        logic [minv_pkg::MAG_W:0] rem2;
        logic [minv_pkg::MAG_W:0] dx;
        logic                     ge;
        d_next = d_in;
        dx = {1'b0, d_in.dm};
        for (int k = 0; k < minv_pkg::NUM_EL; k++)
        begin
            rem2 = {d_in.rem[k], 1'b0};
            ge = (rem2 >= dx);
            d_next.rem[k] = ge ? minv_pkg::MAG_W'(rem2 - dx) : rem2[minv_pkg::MAG_W-1:0];
            d_next.quo[k] = {d_in.quo[k][minv_pkg::DATA_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

endmodule

// ----- hdl/matrix3_inverse_unit.sv -----
// 3x3 fixed point inverse, one matrix per cycle when inv.ready does not stall the
// pipeline; six front stages (products, cofactors, determinant partial products,
// determinant, magnitudes, range check), then 32 restoring division steps of one
// quotient bit each, then the output register.
// asynchronous reset clears all valid bits; payload registers are not reset
module matrix3_inverse_unit (
    input  logic clk,
    input  logic rst_n,
    minv_in_if.sink    mat,
    minv_out_if.source inv
);

    localparam int NE = minv_pkg::NUM_EL;
    localparam int DW = minv_pkg::DATA_W;
    localparam int PW = minv_pkg::PROD_W;
    localparam int CW = minv_pkg::COF_W;
    localparam int TW = minv_pkg::DET_W;
    localparam int MW = minv_pkg::MAG_W;
    localparam int NS = minv_pkg::DIV_STEPS;
    localparam int FS = minv_pkg::FRONT_STG;

    // stall chain: a stage moves when empty or when the next one moves
    logic [FS-1:0] v_reg, vin, en_f;
    logic [NS-1:0] dv, en_d;
    logic          vo_reg, en_o;
    minv_pkg::div_t dd [NS];

    assign en_o = !vo_reg || inv.ready;
    assign en_d[NS-1] = !dv[NS-1] || en_o;
    assign en_f[FS-1] = !v_reg[FS-1] || en_d[0];
    genvar g;
    generate
        for (g = 0; g < NS-1; g++)
        begin : g_end
            assign en_d[g] = !dv[g] || en_d[g+1];
        end
        for (g = 0; g < FS-1; g++)
        begin : g_enf
            assign en_f[g] = !v_reg[g] || en_f[g+1];
        end
    endgenerate
    assign mat.ready = en_f[0];
    assign vin = {v_reg[FS-2:0], mat.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            for (int k = 0; k < FS; k++)
                if (en_f[k])
                    v_reg[k] <= vin[k];
    end

    // stage 1: the eighteen products
    logic signed [PW-1:0] p_next [18];
    logic signed [PW-1:0] p_reg  [18];
    logic signed [DW-1:0] e1_reg [3];

    always_comb
    begin
        p_next[0]  = mat.a11 * mat.a22;  p_next[1]  = mat.a12 * mat.a21;
        p_next[2]  = mat.a12 * mat.a20;  p_next[3]  = mat.a10 * mat.a22;
        p_next[4]  = mat.a10 * mat.a21;  p_next[5]  = mat.a11 * mat.a20;
        p_next[6]  = mat.a02 * mat.a21;  p_next[7]  = mat.a01 * mat.a22;
        p_next[8]  = mat.a00 * mat.a22;  p_next[9]  = mat.a02 * mat.a20;
        p_next[10] = mat.a01 * mat.a20;  p_next[11] = mat.a00 * mat.a21;
        p_next[12] = mat.a01 * mat.a12;  p_next[13] = mat.a02 * mat.a11;
        p_next[14] = mat.a02 * mat.a10;  p_next[15] = mat.a00 * mat.a12;
        p_next[16] = mat.a00 * mat.a11;  p_next[17] = mat.a01 * mat.a10;
    end

    always_ff @(posedge clk)
    begin
        if (en_f[0])
        begin
            p_reg <= p_next;
            e1_reg[0] <= mat.a00;
            e1_reg[1] <= mat.a10;
            e1_reg[2] <= mat.a20;
        end
    end

    // stage 2: cofactors, exact in 65 bits
    logic signed [CW-1:0] c_next [NE];
    logic signed [CW-1:0] c2_reg [NE];
    logic signed [DW-1:0] e2_reg [3];

    always_comb
    begin
        for (int k = 0; k < NE; k++)
            c_next[k] = CW'(p_reg[2*k]) - CW'(p_reg[2*k+1]);
    end

    always_ff @(posedge clk)
    begin
        if (en_f[1])
        begin
            c2_reg <= c_next;
            e2_reg <= e1_reg;
        end
    end

    // stage 3: first-column terms split into high and low partial products
    logic signed [PW-1:0]   ph_next [3];
    logic signed [PW+1:0]   pl_next [3];
    logic signed [PW-1:0]   ph_reg  [3];
    logic signed [PW+1:0]   pl_reg  [3];
    logic signed [CW-1:0]   c3_reg  [NE];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ph_next[i] = e2_reg[i] * $signed(c2_reg[3*i][CW-1:DW+1]);
            pl_next[i] = (PW+2)'(e2_reg[i]) * $signed({1'b0, c2_reg[3*i][DW:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f[2])
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
            c3_reg <= c2_reg;
        end
    end

    // stage 4: determinant
    logic signed [TW-1:0] det_next, det_reg;
    logic signed [CW-1:0] c4_reg [NE];

    always_comb
    begin
        det_next = '0;
        for (int i = 0; i < 3; i++)
            det_next = det_next + (TW'(ph_reg[i]) <<< (DW+1)) + TW'(pl_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en_f[3])
        begin
            det_reg <= det_next;
            c4_reg  <= c3_reg;
        end
    end

    // stage 5: magnitudes and signs, cofactors transposed into output order
    logic [MW-1:0]  dm_next, dm_reg;
    logic [PW-1:0]  cm_next [NE];
    logic [PW-1:0]  cm_reg  [NE];
    logic [NE-1:0]  neg_next, neg_reg;
    logic           sing_reg;

    always_comb
    begin
        logic signed [CW-1:0] cc;
        logic signed [TW-1:0] da;
        da = det_reg[TW-1] ? -det_reg : det_reg;
        dm_next = da[MW-1:0];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                cc = c4_reg[3*j+i];
                cm_next[3*i+j]  = cc[CW-1] ? PW'(-cc) : PW'(cc);
                neg_next[3*i+j] = cc[CW-1] ^ det_reg[TW-1];
            end
    end

    always_ff @(posedge clk)
    begin
        if (en_f[4])
        begin
            dm_reg   <= dm_next;
            cm_reg   <= cm_next;
            neg_reg  <= neg_next;
            sing_reg <= (det_reg == '0);
        end
    end

    // stage 6: quotient of 2^32 or more saturates; otherwise cofactor is the first remainder
    minv_pkg::div_t d0_next, d0_reg;

    always_comb
    begin
        d0_next.dm   = dm_reg;
        d0_next.neg  = neg_reg;
        d0_next.sing = sing_reg;
        for (int k = 0; k < NE; k++)
        begin
            d0_next.rem[k] = MW'(cm_reg[k]);
            d0_next.quo[k] = '0;
            d0_next.big[k] = (MW'(cm_reg[k]) >= dm_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f[5])
            d0_reg <= d0_next;
    end

    generate
        for (g = 0; g < NS; g++)
        begin : g_div
            if (g == 0)
            begin : g_first
                minv_div_step u_step (
                    .clk(clk), .rst_n(rst_n), .en(en_d[g]),
                    .vld_in(v_reg[FS-1]), .d_in(d0_reg),
                    .vld_reg(dv[g]), .d_reg(dd[g])
                );
            end
            else
            begin : g_rest
                minv_div_step u_step (
                    .clk(clk), .rst_n(rst_n), .en(en_d[g]),
                    .vld_in(dv[g-1]), .d_in(dd[g-1]),
                    .vld_reg(dv[g]), .d_reg(dd[g])
                );
            end
        end
    endgenerate

    // output stage: sign, saturation, singular override
    logic [DW-1:0] r_next [NE];
    logic [DW-1:0] r_reg  [NE];
    logic          ov_next, ov_reg, so_reg;

    always_comb
    begin
        logic [DW-1:0] q;
        logic          sat;
        ov_next = 1'b0;
        for (int k = 0; k < NE; k++)
        begin
            q = dd[NS-1].quo[k];
            if (dd[NS-1].neg[k])
            begin
                sat = dd[NS-1].big[k] || (q > {1'b1, {(DW-1){1'b0}}});
                r_next[k] = sat ? {1'b1, {(DW-1){1'b0}}} : -q;
            end
            else
            begin
                sat = dd[NS-1].big[k] || q[DW-1];
                r_next[k] = sat ? {1'b0, {(DW-1){1'b1}}} : q;
            end
            if (dd[NS-1].sing)
            begin
                r_next[k] = '0;
                sat = 1'b0;
            end
            ov_next = ov_next | sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en_o)
            vo_reg <= dv[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            r_reg  <= r_next;
            ov_reg <= ov_next;
            so_reg <= dd[NS-1].sing;
        end
    end

    assign inv.valid      = vo_reg;
    assign inv.r00        = r_reg[0];
    assign inv.r01        = r_reg[1];
    assign inv.r02        = r_reg[2];
    assign inv.r10        = r_reg[3];
    assign inv.r11        = r_reg[4];
    assign inv.r12        = r_reg[5];
    assign inv.r20        = r_reg[6];
    assign inv.r21        = r_reg[7];
    assign inv.r22        = r_reg[8];
    assign inv.singular   = so_reg;
    assign inv.overflowed = ov_reg;

endmodule
